[design/cpc_pkg.sv]
// Shared types and codes for the diagonal pairing codec.
// No dependencies; the interfaces and the top level import this package.
package cpc_pkg;

    // Kind of request carried by one input item.
    typedef logic req_kind_t;

    localparam req_kind_t REQ_ENCODE = 1'b0;
    localparam req_kind_t REQ_DECODE = 1'b1;

endpackage

[design/cpc_req_if.sv]
// Request channel of the pairing codec: valid/ready plus one request item.
// Depends on cpc_pkg for the request kind type.
interface cpc_req_if #(
    parameter int COORD_BITS = 16
);
    import cpc_pkg::*;

    localparam int CODE_W = 2 * COORD_BITS + 2;

    logic                  valid;
    logic                  ready;
    req_kind_t             req_type;
    logic [COORD_BITS-1:0] x_in;
    logic [COORD_BITS-1:0] y_in;
    logic [CODE_W-1:0]     code_in;

    modport source (
        output valid,
        output req_type,
        output x_in,
        output y_in,
        output code_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  x_in,
        input  y_in,
        input  code_in,
        output ready
    );

endinterface

[design/cpc_rsp_if.sv]
// Result channel of the pairing codec: valid/ready plus one result item.
// Depends on cpc_pkg, imported for consistency with the request channel.
interface cpc_rsp_if #(
    parameter int COORD_BITS = 16
);
    import cpc_pkg::*;

    localparam int CODE_W = 2 * COORD_BITS + 2;

    logic                  valid;
    logic                  ready;
    logic [CODE_W-1:0]     code_out;
    logic [COORD_BITS-1:0] x_out;
    logic [COORD_BITS-1:0] y_out;
    logic                  out_of_range;

    modport source (
        output valid,
        output code_out,
        output x_out,
        output y_out,
        output out_of_range,
        input  ready
    );

    modport sink (
        input  valid,
        input  code_out,
        input  x_out,
        input  y_out,
        input  out_of_range,
        output ready
    );

endinterface

[design/cantor_pairing_codec.sv]
// Diagonal pairing codec: encodes a coordinate pair into one code or decodes
// a code into a pair. Depends on cpc_pkg, cpc_req_if and cpc_rsp_if.
//
// Usage:
// - Requests arrive on the req channel and results leave on the rsp channel;
//   both are valid/ready, and an item moves when valid and ready are high.
// - req_type selects encode or decode. Every request yields exactly one
//   result item, in request order.
// - The user must write signed_mode through cfg_we/cfg_wdata while the
//   block is idle; the block does not enforce this. In signed mode the
//   coordinates are two's complement values folded by a zigzag map before
//   pairing and unfolded after decoding. The pipeline has one input stage,
//   COORD_BITS + 3 square-root stages that each settle one root bit, and
//   two stages that form the pair, the second being the output register.
// - One item per cycle unless the skid is full; encode runs its multiplier
//   alongside the square-root stages so both kinds share the same pipeline.
// - When the receiver stalls, a one-item skid buffer behind the output
//   register takes the waiting result and the pipeline freezes while the
//   buffer is full; nothing is lost or repeated.
// - Reset empties the pipeline and the skid buffer and clears signed_mode.
module cantor_pairing_codec #(
    parameter int COORD_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    cpc_req_if.sink        req,
    cpc_rsp_if.source      rsp
);
    import cpc_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int CODE_W = 2 * COORD_BITS + 2;
    localparam int ZZ_W   = COORD_BITS + 1;
    localparam int SUM_W  = COORD_BITS + 2;
    localparam int PROD_W = 2 * SUM_W;
    localparam int RT_W   = COORD_BITS + 3;
    localparam int REM_W  = RT_W + 2;
    localparam int OPND_W = 2 * RT_W;
    localparam int DIAG_W = RT_W - 1;
    localparam int ED_W   = RT_W + 3;
    localparam int LAST   = RT_W + 2;

    // Configuration register.
    logic signed_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            signed_mode_reg <= cfg_wdata;
        end
    end

    // Pipeline control: stage 0 is the input stage, stages 1 to RT_W run the
    // square root, then two pair-forming stages, the last one being the
    // output register. The whole pipeline advances unless the skid is full.
    logic            pipe_en;
    logic            skid_full_reg;
    logic [LAST:0]   vld_reg;
    req_kind_t [LAST-1:0] kind_reg;

    assign pipe_en   = !skid_full_reg;
    assign req.ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            kind_reg <= {kind_reg[LAST-2:0], req.req_type};
        end
    end

    // Input stage: zigzag fold, diagonal sum and the square-root operand.
    logic [ZZ_W-1:0]  x_fold;
    logic [ZZ_W-1:0]  y_fold;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum1_next;
    logic [ZZ_W-1:0]  sel_next;

    always_comb
    begin
        if (signed_mode_reg)
        begin
            x_fold = {req.x_in, 1'b0} ^ {ZZ_W{req.x_in[CB-1]}};
            y_fold = {req.y_in, 1'b0} ^ {ZZ_W{req.y_in[CB-1]}};
        end
        else
        begin
            x_fold = {1'b0, req.x_in};
            y_fold = {1'b0, req.y_in};
        end
        sum_next  = SUM_W'(x_fold) + SUM_W'(y_fold);
        sum1_next = SUM_W'(x_fold) + SUM_W'(y_fold) + SUM_W'(1);
        // Odd diagonals count along y, even ones along x.
        sel_next  = (x_fold[0] ^ y_fold[0]) ? y_fold : x_fold;
    end

    logic [SUM_W-1:0]  enc_sum_reg;
    logic [SUM_W-1:0]  enc_sum1_reg;
    logic [ZZ_W-1:0]   enc_sel_reg;
    logic [REM_W-1:0]  sq_rem_reg  [0:RT_W];
    logic [RT_W-1:0]   sq_root_reg [0:RT_W];
    logic [OPND_W-1:0] sq_opnd_reg [0:RT_W];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            enc_sum_reg    <= sum_next;
            enc_sum1_reg   <= sum1_next;
            enc_sel_reg    <= sel_next;
            // The root of 8*code+1 gives the diagonal without a multiplier.
            sq_opnd_reg[0] <= {1'b0, req.code_in, 3'b001};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // Encode path: triangular number product, then the code itself.
    logic [PROD_W-1:0] enc_prod_reg;
    logic [ZZ_W-1:0]   enc_sel1_reg;
    logic [CODE_W-1:0] enc_code_reg [2:RT_W+1];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            enc_prod_reg    <= PROD_W'(enc_sum_reg) * PROD_W'(enc_sum1_reg);
            enc_sel1_reg    <= enc_sel_reg;
            enc_code_reg[2] <= enc_prod_reg[CODE_W:1] + CODE_W'(enc_sel1_reg);
        end
    end

    for (genvar k = 3; k <= RT_W + 1; k++)
    begin : g_enc_delay
        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                enc_code_reg[k] <= enc_code_reg[k-1];
            end
        end
    end

    // Square-root stages: each brings in two operand bits and settles one
    // root bit by a trial subtraction.
    for (genvar j = 1; j <= RT_W; j++)
    begin : g_sqrt
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;

        always_comb
        begin
            rem_sh = {sq_rem_reg[j-1][REM_W-3:0], sq_opnd_reg[j-1][OPND_W-1 -: 2]};
            trial  = {sq_root_reg[j-1], 2'b01};
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                sq_opnd_reg[j] <= {sq_opnd_reg[j-1][OPND_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    sq_rem_reg[j]  <= rem_sh - trial;
                    sq_root_reg[j] <= {sq_root_reg[j-1][RT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[j]  <= rem_sh;
                    sq_root_reg[j] <= {sq_root_reg[j-1][RT_W-2:0], 1'b0};
                end
            end
        end
    end

    // First pair stage: diagonal n = (r-1)/2 and 8*d from the remainder.
    // With an odd root 8d is the remainder; an even root adds 2r-1.
    logic [RT_W-1:0]   root_m1;
    logic [ED_W-1:0]   ed_next;
    logic [ED_W-1:0]   post_ed_reg;
    logic [DIAG_W-1:0] post_n_reg;

    always_comb
    begin
        root_m1 = sq_root_reg[RT_W] - RT_W'(1);
        if (sq_root_reg[RT_W][0])
        begin
            ed_next = ED_W'(sq_rem_reg[RT_W]);
        end
        else
        begin
            ed_next = ED_W'(sq_rem_reg[RT_W]) + ED_W'({sq_root_reg[RT_W], 1'b0})
                      - ED_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            post_ed_reg <= ed_next;
            post_n_reg  <= root_m1[RT_W-1:1];
        end
    end

    // Second pair stage: split the diagonal, check range, unfold, and load
    // the output register.
    logic [DIAG_W-1:0] diag_d;
    logic [DIAG_W-1:0] diag_rest;
    logic [DIAG_W-1:0] xv;
    logic [DIAG_W-1:0] yv;
    logic [CB-1:0]     x_dec;
    logic [CB-1:0]     y_dec;
    logic              oor_dec;

    always_comb
    begin
        diag_d    = post_ed_reg[DIAG_W+2:3];
        diag_rest = post_n_reg - diag_d;
        if (post_n_reg[0])
        begin
            xv = diag_rest;
            yv = diag_d;
        end
        else
        begin
            xv = diag_d;
            yv = diag_rest;
        end
        oor_dec = (|xv[DIAG_W-1:CB]) || (|yv[DIAG_W-1:CB]);
        if (signed_mode_reg)
        begin
            x_dec = xv[0] ? ~xv[CB:1] : xv[CB:1];
            y_dec = yv[0] ? ~yv[CB:1] : yv[CB:1];
        end
        else
        begin
            x_dec = xv[CB-1:0];
            y_dec = yv[CB-1:0];
        end
    end

    logic [CODE_W-1:0] out_code_reg;
    logic [CB-1:0]     out_x_reg;
    logic [CB-1:0]     out_y_reg;
    logic              out_oor_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            if (kind_reg[LAST-1] == REQ_DECODE)
            begin
                out_code_reg <= '0;
                out_x_reg    <= x_dec;
                out_y_reg    <= y_dec;
                out_oor_reg  <= oor_dec;
            end
            else
            begin
                out_code_reg <= enc_code_reg[RT_W+1];
                out_x_reg    <= '0;
                out_y_reg    <= '0;
                out_oor_reg  <= 1'b0;
            end
        end
    end

    // Skid buffer: catches the output item when the receiver stalls, so the
    // pipeline can take one more step before it freezes.
    logic [CODE_W-1:0] skid_code_reg;
    logic [CB-1:0]     skid_x_reg;
    logic [CB-1:0]     skid_y_reg;
    logic              skid_oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (rsp.ready)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (vld_reg[LAST] && !rsp.ready)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_code_reg <= out_code_reg;
            skid_x_reg    <= out_x_reg;
            skid_y_reg    <= out_y_reg;
            skid_oor_reg  <= out_oor_reg;
        end
    end

    // Result channel: the skid holds the older item whenever it is full.
    always_comb
    begin
        if (skid_full_reg)
        begin
            rsp.valid        = 1'b1;
            rsp.code_out     = skid_code_reg;
            rsp.x_out        = skid_x_reg;
            rsp.y_out        = skid_y_reg;
            rsp.out_of_range = skid_oor_reg;
        end
        else
        begin
            rsp.valid        = vld_reg[LAST];
            rsp.code_out     = out_code_reg;
            rsp.x_out        = out_x_reg;
            rsp.y_out        = out_y_reg;
            rsp.out_of_range = out_oor_reg;
        end
    end

endmodule
